@@ design/config_frame_crc7_unpacker_defines.svh @@
// Assertion macros used by the checker file of the CRC-7 frame unpacker.
`ifndef CONFIG_FRAME_CRC7_UNPACKER_DEFINES_SVH
`define CONFIG_FRAME_CRC7_UNPACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define CFCU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfcu assertion failed");

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define CFCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfcu assertion failed");

`endif

@@ design/cfcu_pkg.sv @@
// Package with the frame layout and CRC-7 constants of the frame unpacker.
package cfcu_pkg;

  localparam int FRAME_LENGTH = 10;
  localparam int BODY_LENGTH  = FRAME_LENGTH - 1;
  localparam int POS_W        = 4;

  localparam logic [6:0] CRC_POLY = 7'h09;
  localparam logic [6:0] CRC_ZERO = 7'h00;

  localparam logic [POS_W-1:0] POS_FIRST = '0;
  localparam logic [POS_W-1:0] POS_FINAL = POS_W'(BODY_LENGTH);

  typedef logic [7:0]       byte_t;
  typedef logic [6:0]       crc_t;
  typedef logic [POS_W-1:0] pos_t;

endpackage

@@ design/cfcu_crc7_step.sv @@
// One-byte CRC-7 update, x^7+x^3+1, MSB first, all eight bits.
module cfcu_crc7_step (
  input  cfcu_pkg::crc_t  crc_in,
  input  cfcu_pkg::byte_t data_in,
  output cfcu_pkg::crc_t  crc_out
);
  import cfcu_pkg::*;

  // Eight shift steps; bit 7 showing up folds back through the polynomial
  always_comb begin
    logic [7:0] t;
    t = {1'b0, crc_in};
    for (int k = 7; k >= 0; k--) begin
      t = {t[6:0], data_in[k]};
      if (t[7]) begin
        t = {1'b0, t[6:0] ^ CRC_POLY};
      end
    end
    crc_out = t[6:0];
  end

endmodule

@@ design/config_frame_crc7_unpacker.sv @@
// Top level of the CRC-7 configuration frame unpacker.
// Takes one frame byte per clock while in_stall is low: an accepted word lands in the input register,
// and on the check byte the result is written from there into the result register. Throughput is
// one byte per cycle while not stalled, set by the single input register feeding the byte-wide CRC
// update and the result register; the input side stalls only while a result is held by out_stall and
// another byte already waits in the input register. A frame is nine body bytes and a check byte; a byte with
// in_frame_start high always begins a new frame, dropping any partial one. Bad frames give
// out_crc_ok low with every other field zero.
module config_frame_crc7_unpacker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cfcu_pkg::byte_t in_data_byte,
  input  logic            in_frame_start,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_crc_ok,
  output cfcu_pkg::byte_t out_device_id,
  output logic [23:0]     out_date_word,
  output logic [15:0]     out_time_word,
  output logic [15:0]     out_temp_poll_time,
  output cfcu_pkg::byte_t out_mag_poll_time
);
  import cfcu_pkg::*;

  // Input register
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_start_r;

  // Frame state
  pos_t  pos_r, pos_nxt;
  crc_t  crc_r, crc_nxt;
  byte_t frame_bytes_r [BODY_LENGTH];

  // Result register
  logic        out_valid_r;
  logic        crc_ok_r;
  byte_t       device_id_r;
  logic [23:0] date_word_r;
  logic [15:0] time_word_r;
  logic [15:0] temp_poll_r;
  byte_t       mag_poll_r;

  logic  adv;
  logic  is_final;
  logic  ok;
  pos_t  pos_cur;
  crc_t  crc_cur;
  crc_t  crc_upd;

  // Stage advances unless a result sits unaccepted
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !adv;

  // Start of frame clears position and remainder first
  assign pos_cur  = s1_start_r ? POS_FIRST : pos_r;
  assign crc_cur  = s1_start_r ? CRC_ZERO : crc_r;
  assign is_final = (pos_cur >= POS_FINAL);
  assign ok       = ({1'b0, crc_cur} == s1_byte_r);

  cfcu_crc7_step u_crc (
    .crc_in  (crc_cur),
    .data_in (s1_byte_r),
    .crc_out (crc_upd)
  );

  // Next frame state
  always_comb begin
    if (is_final) begin
      pos_nxt = POS_FIRST;
      crc_nxt = CRC_ZERO;
    end else begin
      pos_nxt = pos_cur + 1'b1;
      crc_nxt = crc_upd;
    end
  end

  // Input register and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= POS_FIRST;
      crc_r      <= CRC_ZERO;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv && s1_valid_r) begin
        pos_r <= pos_nxt;
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_frame_start;
    end
  end

  // Body byte storage, one register per frame position
  for (genvar i = 0; i < BODY_LENGTH; i++) begin : g_body
    always_ff @(posedge clk) begin
      if (adv && s1_valid_r && !is_final && pos_cur == POS_W'(i)) begin
        frame_bytes_r[i] <= s1_byte_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r && is_final) begin
      crc_ok_r <= ok;
      if (ok) begin
        device_id_r <= frame_bytes_r[0];
        date_word_r <= {frame_bytes_r[3], frame_bytes_r[2], frame_bytes_r[1]};
        time_word_r <= {frame_bytes_r[4], frame_bytes_r[5]};
        temp_poll_r <= {frame_bytes_r[6], frame_bytes_r[7]};
        mag_poll_r  <= frame_bytes_r[8];
      end else begin
        device_id_r <= '0;
        date_word_r <= '0;
        time_word_r <= '0;
        temp_poll_r <= '0;
        mag_poll_r  <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_crc_ok         = crc_ok_r;
  assign out_device_id      = device_id_r;
  assign out_date_word      = date_word_r;
  assign out_time_word      = time_word_r;
  assign out_temp_poll_time = temp_poll_r;
  assign out_mag_poll_time  = mag_poll_r;

endmodule

@@ design/cfcu_checker.sv @@
// Port-level checker for the CRC-7 frame unpacker, bound to the top level.
`include "config_frame_crc7_unpacker_defines.svh"

module cfcu_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input cfcu_pkg::byte_t in_data_byte,
  input logic            in_frame_start,
  input logic            out_valid,
  input logic            out_stall,
  input logic            out_crc_ok,
  input cfcu_pkg::byte_t out_device_id,
  input logic [23:0]     out_date_word,
  input logic [15:0]     out_time_word,
  input logic [15:0]     out_temp_poll_time,
  input cfcu_pkg::byte_t out_mag_poll_time
);
  import cfcu_pkg::*;

  // A stalled input word stays and keeps its payload
  `CFCU_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_data_byte) && $stable(in_frame_start))

  // A stalled result word stays and keeps its payload
  `CFCU_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_crc_ok) && $stable(out_date_word) && $stable(out_device_id))

  // Input is held off only behind a stalled result
  `CFCU_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall)

  // A failed frame reports all fields as zero
  `CFCU_ASSERT_NOW(a_fail_zero, out_valid && !out_crc_ok,
    out_device_id == '0 && out_date_word == '0 && out_time_word == '0 &&
    out_temp_poll_time == '0 && out_mag_poll_time == '0)

endmodule

bind config_frame_crc7_unpacker cfcu_checker u_cfcu_checker (.*);

@@ test/config_frame_crc7_unpacker_tb.sv @@
// Self-checking testbench for the CRC-7 configuration frame unpacker.
`timescale 1ns / 1ps

module config_frame_crc7_unpacker_tb;
  import cfcu_pkg::*;

  localparam int     CLK_HALF_NS  = 6;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     SETTLE_TICKS = 20;
  localparam int     PHASE_WORDS  = 340;
  localparam longint RUN_LIMIT_NS = 64'd12 * 64'd400_000;

  typedef enum {PH_STEADY, PH_SPARSE_IN, PH_SLOW_OUT, PH_BOTH} phase_t;
  typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_TOP_BIT, FRAME_CUT, LINE_NOISE} frame_kind_t;

  typedef struct packed {
    byte_t data;
    logic  start;
  } stim_word_t;

  typedef struct packed {
    logic        crc_ok;
    byte_t       device_id;
    logic [23:0] date_word;
    logic [15:0] time_word;
    logic [15:0] temp_poll_time;
    byte_t       mag_poll_time;
  } frame_result_t;

  // DUT ports; the driven inputs are known from time zero
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  byte_t       in_data_byte   = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_crc_ok;
  byte_t       out_device_id;
  logic [23:0] out_date_word;
  logic [15:0] out_time_word;
  logic [15:0] out_temp_poll_time;
  byte_t       out_mag_poll_time;

  config_frame_crc7_unpacker DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_crc_ok        (out_crc_ok),
    .out_device_id     (out_device_id),
    .out_date_word     (out_date_word),
    .out_time_word     (out_time_word),
    .out_temp_poll_time(out_temp_poll_time),
    .out_mag_poll_time (out_mag_poll_time)
  );

  // Stimulus and scoreboard state
  stim_word_t    pending_words[$];
  frame_result_t expected_frames[$];
  phase_t        phase        = PH_STEADY;
  bit            word_taken   = 1'b0;
  int            holds_asked  = 0;
  int            holds_served = 0;
  int            hold_left    = 0;
  int            words_queued = 0;
  int            words_in     = 0;
  int            frames_out   = 0;
  int            frames_good  = 0;
  int            mismatch_count = 0;

  // Predictor state: position, running remainder and stored body bytes
  pos_t  frame_pos = POS_FIRST;
  crc_t  frame_crc = CRC_ZERO;
  byte_t frame_store [BODY_LENGTH];

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: run did not finish in time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Shift one byte MSB first through the x^7+x^3+1 remainder
  function automatic crc_t crc7_feed(crc_t crc, byte_t b);
    crc_t t;
    t = crc;
    for (int k = 7; k >= 0; k--) begin
      if (t[6]) t = {t[5:0], b[k]} ^ CRC_POLY;
      else t = {t[5:0], b[k]};
    end
    return t;
  endfunction

  // Advance the predicted frame by one word; done is set on the check byte
  function automatic void unpack_frame_byte(input byte_t b, input logic start,
                                            output bit done, output frame_result_t r);
    r    = '0;
    done = 1'b0;
    if (start) begin
      frame_pos = POS_FIRST;
      frame_crc = CRC_ZERO;
    end
    if (frame_pos < BODY_LENGTH) begin
      frame_store[frame_pos] = b;
      frame_crc = crc7_feed(frame_crc, b);
      frame_pos = frame_pos + 1'b1;
    end else begin
      done     = 1'b1;
      r.crc_ok = ({1'b0, frame_crc} == b);
      // bad frames leave every field zero
      if (r.crc_ok) begin
        r.device_id      = frame_store[0];
        r.date_word      = {frame_store[3], frame_store[2], frame_store[1]};
        r.time_word      = {frame_store[4], frame_store[5]};
        r.temp_poll_time = {frame_store[6], frame_store[7]};
        r.mag_poll_time  = frame_store[8];
      end
      frame_pos = POS_FIRST;
      frame_crc = CRC_ZERO;
    end
  endfunction

  task automatic flag_mismatch(string what, logic [23:0] got, logic [23:0] want);
    if (mismatch_count < 30)
      $display("ERROR @%0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_byte(byte_t b, logic s);
    pending_words.push_back('{data: b, start: s});
    words_queued++;
  endtask

  // Queue one frame of the given kind with random body bytes, or a short burst of noise bytes
  task automatic push_frame(frame_kind_t kind, bit lead_start);
    byte_t body [BODY_LENGTH];
    crc_t  crc;
    int    cut;
    crc = CRC_ZERO;
    if (kind == LINE_NOISE) begin
      cut = $urandom_range(5, 1);
      for (int i = 0; i < cut; i++) push_byte(byte_t'($urandom), $urandom_range(7) == 0);
    end else begin
      for (int i = 0; i < BODY_LENGTH; i++) begin
        body[i] = byte_t'($urandom);
        crc = crc7_feed(crc, body[i]);
      end
      cut = (kind == FRAME_CUT) ? $urandom_range(BODY_LENGTH - 1, 1) : BODY_LENGTH;
      for (int i = 0; i < cut; i++) push_byte(body[i], (i == 0) && lead_start);
      case (kind)
        FRAME_GOOD: begin
          push_byte({1'b0, crc}, 1'b0);
        end
        FRAME_BAD_CRC: begin
          push_byte({1'b0, crc ^ crc_t'($urandom_range(127, 1))}, 1'b0);
        end
        FRAME_TOP_BIT: begin
          push_byte({1'b1, 7'($urandom)}, 1'b0);
        end
        default: begin
          // partial frame dropped by a fresh start in mid-frame
          push_frame(FRAME_GOOD, 1'b1);
        end
      endcase
    end
  endtask

  // Mostly well-formed frames, some broken ones and a little noise
  task automatic random_traffic(int n_words);
    int target;
    int pick;
    target = words_queued + n_words;
    while (words_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 65) push_frame(FRAME_GOOD, $urandom_range(3) != 0);
      else if (pick < 77) push_frame(FRAME_BAD_CRC, $urandom_range(3) != 0);
      else if (pick < 83) push_frame(FRAME_TOP_BIT, 1'b1);
      else if (pick < 93) push_frame(FRAME_CUT, 1'b1);
      else push_frame(LINE_NOISE, 1'b0);
    end
  endtask

  // Sender holds off until every queued word is in and every frame is out
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
  endtask

  // Driver: present the next word once the current one is taken
  always @(negedge clk) begin : drive_words
    stim_word_t w;
    int idle_pct;
    idle_pct = (phase == PH_SPARSE_IN) ? 83 : (phase == PH_BOTH) ? 34 : 0;
    if (rst_n && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = pending_words.pop_front();
        in_valid       <= 1'b1;
        in_data_byte   <= w.data;
        in_frame_start <= w.start;
      end else begin
        in_valid       <= 1'b0;
        in_data_byte   <= byte_t'($urandom);
        in_frame_start <= 1'($urandom_range(1));
      end
    end
  end

  // Receiver: random stall per phase, plus long hold-offs on request
  always @(negedge clk) begin : drive_stall
    int stall_pct;
    stall_pct = (phase == PH_SLOW_OUT) ? 83 : (phase == PH_BOTH) ? 34 : 0;
    if (rst_n) begin
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Monitor: predict on each accepted input word, check each accepted result
  always @(posedge clk) begin : watch_ports
    frame_result_t r;
    frame_result_t want;
    bit done;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        word_taken = 1'b1;
        words_in++;
        unpack_frame_byte(in_data_byte, in_frame_start, done, r);
        if (done) expected_frames.push_back(r);
      end
      if (out_valid && !out_stall) begin
        frames_out++;
        if (out_crc_ok) frames_good++;
        if (expected_frames.size() == 0) begin
          flag_mismatch("result with no frame pending, crc_ok", 24'(out_crc_ok), '0);
        end else begin
          want = expected_frames.pop_front();
          if (out_crc_ok !== want.crc_ok)
            flag_mismatch("crc_ok", 24'(out_crc_ok), 24'(want.crc_ok));
          if (out_device_id !== want.device_id)
            flag_mismatch("device_id", 24'(out_device_id), 24'(want.device_id));
          if (out_date_word !== want.date_word)
            flag_mismatch("date_word", out_date_word, want.date_word);
          if (out_time_word !== want.time_word)
            flag_mismatch("time_word", 24'(out_time_word), 24'(want.time_word));
          if (out_temp_poll_time !== want.temp_poll_time)
            flag_mismatch("temp_poll_time", 24'(out_temp_poll_time),
                          24'(want.temp_poll_time));
          if (out_mag_poll_time !== want.mag_poll_time)
            flag_mismatch("mag_poll_time", 24'(out_mag_poll_time), 24'(want.mag_poll_time));
        end
      end
    end
  end

  // Sequence: reset, directed frames, steady traffic, long hold, three more idle patterns, drain
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all-zero frame, remainder zero, check byte zero
    for (int i = 0; i < BODY_LENGTH; i++) push_byte(8'h00, i == 0);
    push_byte(8'h00, 1'b0);
    // all-ones frame with no frame start; check byte has bit 7 set
    for (int i = 0; i < BODY_LENGTH; i++) push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    // partial frame of three bytes with no check byte
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hFF, 1'b0);
    wait_drained();

    phase = PH_STEADY;
    random_traffic(PHASE_WORDS);
    wait_drained();

    // receiver holds off while the sender keeps offering words
    holds_asked++;
    for (int i = 0; i < 6; i++) push_frame(FRAME_GOOD, 1'b1);
    wait_drained();

    phase = PH_SPARSE_IN;
    random_traffic(PHASE_WORDS);
    wait_drained();

    phase = PH_SLOW_OUT;
    random_traffic(PHASE_WORDS);
    wait_drained();

    phase = PH_BOTH;
    random_traffic(PHASE_WORDS);
    wait_drained();

    phase = PH_STEADY;
    repeat (SETTLE_TICKS) @(posedge clk);
    if (expected_frames.size() != 0)
      flag_mismatch("frames never emitted", 24'(expected_frames.size()), '0);

    $display("Covered %0d input words and %0d frames out, %0d with a good CRC,",
             words_in, frames_out, frames_good);
    $display("under steady, sparse-input, slow-output and mixed idling plus a long hold.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
